@@ src/cksrc_pkg.sv @@
// Shared types and constants for the color-key sprite run clipper.
package cksrc_pkg;

    localparam int DIM_W      = 10;  // sprite dimension and sprite coordinate width
    localparam int POS_W      = 18;  // signed screen coordinate width, no wrap
    localparam int OUT_W      = 9;   // width of every result field
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 3'd4;

    // Closed run in sprite coordinates, half-open [start, end_col)
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] start;
        logic [DIM_W-1:0] end_col;
    } t_run;

    typedef struct packed {
        logic [OUT_W-1:0] dest_x;
        logic [OUT_W-1:0] dest_y;
        logic [OUT_W-1:0] run_length;
        logic [OUT_W-1:0] source_row;
        logic [OUT_W-1:0] source_col;
    } t_run_out;

endpackage

@@ src/color_key_sprite_run_clipper.sv @@
// Color-key sprite run clipper: takes one RGB565 sprite pixel per clock in raster order,
// tracks column and row itself, and emits each opaque run, clipped to the screen, with
// its screen position, length and first visible source pixel. Throughput is one pixel
// per clock while the result side does not stall; a result passes through one register
// for the closed run and one for the clipped result before it leaves. Rows and runs
// wholly off screen produce no transaction. Counters wrap to the first pixel of the
// next sprite after the last row. Write configuration only while idle.
module color_key_sprite_run_clipper import cksrc_pkg::*; #(
    parameter int SCREEN_WIDTH   = 480,
    parameter int SCREEN_HEIGHT  = 272,
    parameter int MAX_SPRITE_DIM = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_stall,
    input  logic [15:0]           i_pixel,
    // run output
    output logic                  o_run_valid,
    input  logic                  i_run_stall,
    output logic [OUT_W-1:0]      o_dest_x,
    output logic [OUT_W-1:0]      o_dest_y,
    output logic [OUT_W-1:0]      o_run_length,
    output logic [OUT_W-1:0]      o_source_row,
    output logic [OUT_W-1:0]      o_source_col
);

    localparam int EFF_MAX = (MAX_SPRITE_DIM > 1023) ? 1023 : MAX_SPRITE_DIM;
    localparam int CNT_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

    logic signed [15:0] r_pos_x;
    logic signed [15:0] r_pos_y;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [15:0]        r_key;

    logic [CNT_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_row;
    logic               r_in_run;
    logic [CNT_W-1:0]   r_run_start;

    logic               r_a_valid;
    t_run               r_a;
    logic               r_out_valid;
    t_run_out           r_out;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [CNT_W:0]     col_inc;
    logic [CNT_W:0]     row_inc;
    logic               last_col;
    logic               last_row;
    logic               opaque;
    logic               closing;
    logic [CNT_W-1:0]   start_sel;
    logic               pix_acc;
    logic               a_ready;
    logic               b_ready;
    t_run               run;
    logic               clip_hit;
    t_run_out           clip_res;

    logic [CNT_W-1:0]   n_col;
    logic [CNT_W-1:0]   n_row;
    logic               n_in_run;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_width) > MAX_SPRITE_DIM) begin
            w_eff = DIM_W'(EFF_MAX);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_height) > MAX_SPRITE_DIM) begin
            h_eff = DIM_W'(EFF_MAX);
        end else begin
            h_eff = r_height;
        end

        col_inc  = {1'b0, r_col} + 1'b1;
        row_inc  = {1'b0, r_row} + 1'b1;
        last_col = (DIM_W+1)'(col_inc) >= {1'b0, w_eff};
        last_row = (DIM_W+1)'(row_inc) >= {1'b0, h_eff};
        opaque   = i_pixel != r_key;

        // a key pixel ends the run before it; the row end closes it after this pixel
        closing   = (opaque && last_col) || (!opaque && r_in_run);
        start_sel = (opaque && !r_in_run) ? r_col : r_run_start;
        n_in_run  = opaque && !last_col;
        n_col     = last_col ? '0 : col_inc[CNT_W-1:0];
        n_row     = last_col ? (last_row ? '0 : row_inc[CNT_W-1:0]) : r_row;

        run.row     = DIM_W'(r_row);
        run.start   = DIM_W'(start_sel);
        run.end_col = opaque ? DIM_W'(col_inc) : DIM_W'(r_col);

        b_ready = !r_out_valid || !i_run_stall;
        a_ready = !r_a_valid || b_ready;
        pix_acc = i_pixel_valid && a_ready;
    end

    assign o_pixel_stall = !a_ready;

    cksrc_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_run   (r_a),
        .o_hit   (clip_hit),
        .o_res   (clip_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_width     <= DIM_W'(1);
            r_height    <= DIM_W'(1);
            r_key       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POS_X:         r_pos_x  <= $signed(i_cfg_data);
                    CFG_POS_Y:         r_pos_y  <= $signed(i_cfg_data);
                    CFG_SPRITE_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_SPRITE_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    CFG_KEY_COLOR:     r_key    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pix_acc) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_in_run    <= n_in_run;
                r_run_start <= start_sel;
            end
            if (a_ready) begin
                r_a_valid <= pix_acc && closing;
            end
            if (b_ready) begin
                r_out_valid <= r_a_valid && clip_hit;
            end
        end
    end

    // payload registers: advance with their stage
    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a <= run;
        end
        if (b_ready) begin
            r_out <= clip_res;
        end
    end

    assign o_run_valid  = r_out_valid;
    assign o_dest_x     = r_out.dest_x;
    assign o_dest_y     = r_out.dest_y;
    assign o_run_length = r_out.run_length;
    assign o_source_row = r_out.source_row;
    assign o_source_col = r_out.source_col;

    a_run_start_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_run_start < r_col))
        else $error("open run starts at or after the current column");

    a_closed_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a.start < r_a.end_col))
        else $error("closed run is empty");

    a_close_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && closing) |=> !r_in_run)
        else $error("run still open after its closing pixel");

    a_run_opens_on_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_run) |-> $past(pix_acc))
        else $error("run opened without an accepted pixel");

endmodule

@@ src/cksrc_clip.sv @@
// Screen clipping of one closed sprite run.
module cksrc_clip import cksrc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 272
) (
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  t_run               i_run,
    output logic               o_hit,
    output t_run_out           o_res
);

    localparam logic signed [POS_W-1:0] SW_S = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] SH_S = POS_W'(SCREEN_HEIGHT);

    logic signed [POS_W-1:0] pos_x_s;
    logic signed [POS_W-1:0] pos_y_s;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pe;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] ce;
    logic signed [POS_W-1:0] cw;
    logic signed [POS_W-1:0] sc;
    logic                    y_ok;
    logic                    x_ok;
    logic                    run_ok;

    always_comb begin
        pos_x_s = $signed({{(POS_W-16){i_pos_x[15]}}, i_pos_x});
        pos_y_s = $signed({{(POS_W-16){i_pos_y[15]}}, i_pos_y});
        py = pos_y_s + $signed({{(POS_W-DIM_W){1'b0}}, i_run.row});
        px = pos_x_s + $signed({{(POS_W-DIM_W){1'b0}}, i_run.start});
        pe = pos_x_s + $signed({{(POS_W-DIM_W){1'b0}}, i_run.end_col});

        y_ok   = !py[POS_W-1] && (py < SH_S);
        x_ok   = !pe[POS_W-1] && (pe != '0) && (px < SW_S);
        run_ok = i_run.start < i_run.end_col;
        o_hit  = y_ok && x_ok && run_ok;

        // clamp both ends to the screen; the first visible source column
        // follows from the clamped start
        cx = px[POS_W-1] ? '0 : px;
        ce = (pe > SW_S) ? SW_S : pe;
        cw = ce - cx;
        sc = cx - pos_x_s;

        o_res.dest_x     = cx[OUT_W-1:0];
        o_res.dest_y     = py[OUT_W-1:0];
        o_res.run_length = cw[OUT_W-1:0];
        o_res.source_row = i_run.row[OUT_W-1:0];
        o_res.source_col = sc[OUT_W-1:0];
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the color-key sprite run clipper.
module testbench;
    import cksrc_pkg::*;

    localparam int SCREEN_W      = 480;
    localparam int SCREEN_H      = 272;
    localparam int MAX_DIM       = 512;
    localparam int RANDOM_PIXELS = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic [15:0]           pixel_data;
    logic                  run_stall;
    logic                  o_pixel_stall;
    logic                  o_run_valid;
    logic [OUT_W-1:0]      o_dest_x;
    logic [OUT_W-1:0]      o_dest_y;
    logic [OUT_W-1:0]      o_run_length;
    logic [OUT_W-1:0]      o_source_row;
    logic [OUT_W-1:0]      o_source_col;

    // shadow of the block's registers
    logic signed [15:0] cfg_pos_x;
    logic signed [15:0] cfg_pos_y;
    logic [9:0]         cfg_width;
    logic [9:0]         cfg_height;
    logic [15:0]        cfg_key;

    // predicted raster position and open run
    int col_cnt;
    int row_cnt;
    bit run_open;
    int run_first;

    t_run_out expected_runs[$];
    int       mismatch_count;
    int       gap_pct;
    int       stall_pct;
    int       result_hold_req;

    color_key_sprite_run_clipper u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_pixel_valid (pixel_valid),
        .o_pixel_stall (o_pixel_stall),
        .i_pixel       (pixel_data),
        .o_run_valid   (o_run_valid),
        .i_run_stall   (run_stall),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .o_run_length  (o_run_length),
        .o_source_row  (o_source_row),
        .o_source_col  (o_source_col)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_dim(logic [9:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic logic [15:0] random_pixel(int key_pct);
        logic [15:0] p;
        if ($urandom_range(99) < key_pct) return cfg_key;
        case ($urandom_range(9))
            0: p = cfg_key ^ (16'h1 << $urandom_range(15));
            1: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: p = 16'($urandom);
        endcase
        if (p == cfg_key) p = ~cfg_key;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Advance the raster position by one pixel and queue the clipped run it closes.
    task automatic predict_pixel(input logic [15:0] p);
        int w, h, stop, py, px, len, skip, cx, cw;
        bit last, closing;
        t_run_out run;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        closing = 1'b0;
        stop = 0;
        last = (col_cnt + 1 >= w);
        if (p != cfg_key) begin
            if (!run_open) begin
                run_first = col_cnt;
                run_open = 1'b1;
            end
        end else if (run_open) begin
            closing = 1'b1;
            stop = col_cnt;
            run_open = 1'b0;
        end
        if (last && run_open) begin
            closing = 1'b1;
            stop = col_cnt + 1;
            run_open = 1'b0;
        end
        if (closing) begin
            py = int'(cfg_pos_y) + row_cnt;
            px = int'(cfg_pos_x) + run_first;
            len = stop - run_first;
            if (py >= 0 && py < SCREEN_H && len > 0 && px + len > 0 && px < SCREEN_W) begin
                skip = (px < 0) ? -px : 0;
                cx = (px < 0) ? 0 : px;
                cw = len - skip;
                if (cx + cw > SCREEN_W) cw = SCREEN_W - cx;
                if (cw > 0) begin
                    run.dest_x     = 9'(cx);
                    run.dest_y     = 9'(py);
                    run.run_length = 9'(cw);
                    run.source_row = 9'(row_cnt);
                    run.source_col = 9'(run_first + skip);
                    expected_runs.push_back(run);
                end
            end
        end
        if (last) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        case (idx)
            CFG_POS_X:         cfg_pos_x = value;
            CFG_POS_Y:         cfg_pos_y = value;
            CFG_SPRITE_WIDTH:  cfg_width = value[9:0];
            CFG_SPRITE_HEIGHT: cfg_height = value[9:0];
            CFG_KEY_COLOR:     cfg_key = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one pixel after an optional gap; valid stays high on return.
    task automatic send_pixel(input logic [15:0] p);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0) begin
            pixel_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid = 1'b1;
        pixel_data = p;
        do @(posedge clk); while (o_pixel_stall);
        predict_pixel(p);
    endtask

    // Drop valid, wait for every queued run, then let the pipeline flush.
    task automatic drain_runs();
        int guard, quiet;
        @(negedge clk);
        pixel_valid = 1'b0;
        guard = 0;
        quiet = 0;
        while ((expected_runs.size() > 0 || quiet < 4) && guard < 50000) begin
            @(posedge clk);
            guard++;
            if (expected_runs.size() == 0 && !run_stall) quiet++;
            else quiet = 0;
        end
    endtask

    task automatic test_reset_state();
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        drain_runs();
    endtask

    // Left, right and bottom clipping, an off-screen row, key at row end.
    task automatic test_clipping();
        logic [15:0] left_rows [8];
        logic [15:0] right_rows [8];
        left_rows  = '{16'h1235, 16'hEDCB, 16'h1234, 16'h1235,
                       16'hEDCB, 16'h1235, 16'hEDCB, 16'h1235};
        right_rows = '{16'hEDCB, 16'h1235, 16'hEDCB, 16'h1235,
                       16'h1235, 16'hEDCB, 16'h1235, 16'h1234};
        write_reg(CFG_SPRITE_WIDTH, 16'd4);
        write_reg(CFG_SPRITE_HEIGHT, 16'd2);
        write_reg(CFG_KEY_COLOR, 16'h1234);
        write_reg(CFG_POS_X, 16'hFFFE);
        write_reg(CFG_POS_Y, 16'd271);
        foreach (left_rows[i]) send_pixel(left_rows[i]);
        drain_runs();
        write_reg(CFG_POS_X, 16'd478);
        write_reg(CFG_POS_Y, 16'd0);
        foreach (right_rows[i]) send_pixel(right_rows[i]);
        drain_runs();
    endtask

    // Zero and oversize dimensions, far-off positions, extreme key colors.
    task automatic test_dimension_limits();
        write_reg(CFG_SPRITE_WIDTH, 16'd0);
        write_reg(CFG_SPRITE_HEIGHT, 16'd0);
        write_reg(CFG_POS_X, 16'h7FFF);
        write_reg(CFG_POS_Y, 16'h7FFF);
        send_pixel(16'hFFFF);
        drain_runs();
        write_reg(CFG_POS_X, 16'h8000);
        write_reg(CFG_POS_Y, 16'h8000);
        send_pixel(16'h0000);
        drain_runs();
        write_reg(CFG_POS_X, 16'd0);
        write_reg(CFG_POS_Y, 16'd0);
        write_reg(CFG_KEY_COLOR, 16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        drain_runs();
        write_reg(CFG_SPRITE_WIDTH, 16'd1023);
        write_reg(CFG_SPRITE_HEIGHT, 16'd512);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        drain_runs();
    endtask

    // Hold the result side for a long stretch while pixels keep coming.
    task automatic test_result_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        write_reg(CFG_SPRITE_WIDTH, 16'd8);
        write_reg(CFG_SPRITE_HEIGHT, 16'd4);
        write_reg(CFG_KEY_COLOR, 16'h0000);
        write_reg(CFG_POS_X, 16'd0);
        write_reg(CFG_POS_Y, 16'd0);
        result_hold_req = 300;
        repeat (200) send_pixel(random_pixel(20));
        drain_runs();
    endtask

    task automatic test_random_sprites();
        int total, pixels, ew, key_pct;
        logic [9:0] dim;
        total = 0;
        while (total < RANDOM_PIXELS) begin
            drain_runs();
            if ($urandom_range(3) == 0) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 40);
            end
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(29))
                    0: dim = 10'd0;
                    1: dim = 10'($urandom_range(480, 512));
                    2: dim = 10'($urandom_range(513, 1023));
                    default: dim = 10'($urandom_range(1, 24));
                endcase
                write_reg(CFG_SPRITE_WIDTH, {6'($urandom), dim});
            end
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(19))
                    0: dim = 10'd0;
                    1: dim = 10'($urandom_range(512, 1023));
                    default: dim = 10'($urandom_range(1, 6));
                endcase
                write_reg(CFG_SPRITE_HEIGHT, {6'($urandom), dim});
            end
            ew = clamp_dim(cfg_width);
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(9))
                    0: write_reg(CFG_POS_X, 16'($urandom));
                    1: write_reg(CFG_POS_X, $urandom_range(1) ? 16'h8000 : 16'h7FFF);
                    default: write_reg(CFG_POS_X,
                                       16'(int'($urandom_range(0, 510 + ew)) - ew - 10));
                endcase
            end
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(9))
                    0: write_reg(CFG_POS_Y, 16'($urandom));
                    1: write_reg(CFG_POS_Y, $urandom_range(1) ? 16'h8000 : 16'h7FFF);
                    default: write_reg(CFG_POS_Y, 16'(int'($urandom_range(0, 300)) - 18));
                endcase
            end
            if ($urandom_range(99) < 50) begin
                case ($urandom_range(4))
                    0: write_reg(CFG_KEY_COLOR, 16'h0000);
                    1: write_reg(CFG_KEY_COLOR, 16'hFFFF);
                    default: write_reg(CFG_KEY_COLOR, 16'($urandom));
                endcase
            end
            if (ew > 64) pixels = ew;
            else pixels = ew * $urandom_range(1, 10)
                          + (($urandom_range(3) == 0) ? $urandom_range(0, ew - 1) : 0);
            key_pct = $urandom_range(5, 60);
            repeat (pixels) send_pixel(random_pixel(key_pct));
            total += pixels;
        end
    endtask

    // Result side: random stalls, occasional long ones, and requested holds.
    initial begin
        int hold_left;
        run_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (result_hold_req > 0) begin
                hold_left = result_hold_req;
                result_hold_req = 0;
            end
            if (hold_left > 0) begin
                run_stall = 1'b1;
                hold_left--;
            end else if (stall_pct == 0) begin
                run_stall = 1'b0;
            end else if ($urandom_range(99) < 2) begin
                run_stall = 1'b1;
                hold_left = $urandom_range(8, 30);
            end else begin
                run_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted run with the oldest prediction.
    initial begin
        t_run_out want;
        forever begin
            @(posedge clk);
            if (rst_n && o_run_valid && !run_stall) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("run transaction with no expectation pending");
                end else begin
                    want = expected_runs.pop_front();
                    compare_field("dest_x", o_dest_x, want.dest_x);
                    compare_field("dest_y", o_dest_y, want.dest_y);
                    compare_field("run_length", o_run_length, want.run_length);
                    compare_field("source_row", o_source_row, want.source_row);
                    compare_field("source_col", o_source_col, want.source_col);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("color_key_sprite_run_clipper test failed");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_POS_X;
        cfg_data = 16'h0000;
        pixel_valid = 1'b0;
        pixel_data = 16'h0000;
        cfg_pos_x = 16'sd0;
        cfg_pos_y = 16'sd0;
        cfg_width = 10'd1;
        cfg_height = 10'd1;
        cfg_key = 16'h0000;
        col_cnt = 0;
        row_cnt = 0;
        run_open = 1'b0;
        run_first = 0;
        mismatch_count = 0;
        gap_pct = 20;
        stall_pct = 20;
        result_hold_req = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_clipping();
        test_dimension_limits();
        test_result_backpressure();
        test_random_sprites();
        drain_runs();

        if (expected_runs.size() > 0)
            report_mismatch($sformatf("%0d expected runs never arrived",
                                      expected_runs.size()));
        if (mismatch_count == 0) begin
            $display("color_key_sprite_run_clipper test passed");
        end else begin
            $display("color_key_sprite_run_clipper test failed");
        end
        $finish;
    end

endmodule
